>>> rtl/sliding_window_stddev_six_channel_assert.svh
// Assertion macros for the sliding-window standard deviation block.
`ifndef SLIDING_WINDOW_STDDEV_SIX_CHANNEL_ASSERT_SVH
`define SLIDING_WINDOW_STDDEV_SIX_CHANNEL_ASSERT_SVH
`ifndef ASSERT_OFF
// The antecedent implies the consequent in the same cycle.
`define SW6_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The antecedent implies the consequent in the next cycle.
`define SW6_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SW6_ASSERT_IMP(label, ante, cons, msg)
`define SW6_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/sw6_pkg.sv
// Shared constants, payload types and control types of the standard deviation block.
package sw6_pkg;

    localparam int WINDOW     = 100;
    localparam int CHANNELS   = 6;
    localparam int SMP_W      = 16;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int LAST_CH    = CHANNELS - 1;
    localparam int WIN_W      = $clog2(WINDOW + 1);
    localparam int RING_DEPTH = WINDOW * CHANNELS;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int SUM_W      = SMP_W + $clog2(WINDOW) + 1;
    localparam int MAG_W      = SUM_W - 1;
    localparam int SQR_W      = 2 * SMP_W - 1;
    localparam int SQS_W      = SQR_W + $clog2(WINDOW);
    localparam int NUM_W      = 2 * MAG_W;
    localparam int ROOT_W     = SMP_W;
    localparam int SQRT_W     = NUM_W / 2;
    localparam int SREM_W     = SQRT_W + 3;
    localparam int CNT_W      = $clog2(SQRT_W);
    // Reciprocal of WINDOW, exact for every root below 2^SQRT_W.
    localparam int     RECIP_SH = SQRT_W + $clog2(WINDOW);
    localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(WINDOW) - 1)
                                  / longint'(WINDOW);
    localparam int     RECIP_W  = $clog2(RECIP + 1);
    localparam int     PROD_W   = SQRT_W + RECIP_W;

    typedef struct packed {
        logic signed [SMP_W-1:0] accel_x;
        logic signed [SMP_W-1:0] accel_y;
        logic signed [SMP_W-1:0] accel_z;
        logic signed [SMP_W-1:0] gyro_x;
        logic signed [SMP_W-1:0] gyro_y;
        logic signed [SMP_W-1:0] gyro_z;
    } sample_t;

    typedef struct packed {
        logic [ROOT_W-1:0] sd_accel_x;
        logic [ROOT_W-1:0] sd_accel_y;
        logic [ROOT_W-1:0] sd_accel_z;
        logic [ROOT_W-1:0] sd_gyro_x;
        logic [ROOT_W-1:0] sd_gyro_y;
        logic [ROOT_W-1:0] sd_gyro_z;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_ACCUM,
        ST_NEXT,
        ST_PREP,
        ST_DIFF,
        ST_WAIT,
        ST_OUTPUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ROOT,
        PH_SCALE
    } ru_phase_t;

    typedef struct packed {
        logic              capture;
        logic              ring_rd;
        logic              ring_wr;
        logic [ADDR_W-1:0] ring_addr;
        logic [CH_W-1:0]   ch;
        logic              full;
        logic              square;
        logic              accum;
        logic              prep;
        logic              root_start;
        logic              store_root;
        logic              load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic root_done;
    } dp_status_t;

endpackage

>>> rtl/sw6_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sw6_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sw6_divsqrt.sv
// Iterative unit: integer root one digit a cycle, then a reciprocal multiply divides by WINDOW.
module sw6_divsqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sw6_pkg::NUM_W-1:0]  num,
    output logic                       done,
    output logic [sw6_pkg::ROOT_W-1:0] root
);
    import sw6_pkg::*;

    ru_phase_t          phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [NUM_W-1:0]   x_reg, x_next;
    logic [SREM_W-1:0]  srem_reg, srem_next;
    logic [SQRT_W-1:0]  sroot_reg, sroot_next;
    logic [ROOT_W-1:0]  root_reg, root_next;

    logic [SREM_W-1:0]  sq_shift;
    logic [SREM_W-1:0]  sq_trial;
    logic               sq_ge;
    logic [PROD_W-1:0]  scaled;

    always_comb
    begin
        // The remainder of the root stays below 2^(SQRT_W+1), so the dropped bits are zero.
        sq_shift = {srem_reg[SREM_W-3:0], x_reg[NUM_W-1 -: 2]};
        sq_trial = SREM_W'({sroot_reg, 2'b01});
        sq_ge    = sq_shift >= sq_trial;
        // floor(sqrt(floor(n / W^2))) equals floor(floor(sqrt(n)) / W).
        scaled   = PROD_W'(sroot_reg) * PROD_W'(RECIP);
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        srem_next  = srem_reg;
        sroot_next = sroot_reg;
        root_next  = root_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_ROOT;
                    cnt_next   = CNT_W'(SQRT_W - 1);
                    x_next     = num;
                    srem_next  = '0;
                    sroot_next = '0;
                end
            end
            PH_ROOT:
            begin
                x_next     = {x_reg[NUM_W-3:0], 2'b00};
                srem_next  = sq_ge ? sq_shift - sq_trial : sq_shift;
                sroot_next = {sroot_reg[SQRT_W-2:0], sq_ge};
                if (cnt_reg == '0)
                begin
                    phase_next = PH_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            PH_SCALE:
            begin
                root_next  = scaled[RECIP_SH +: ROOT_W];
                done_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        srem_reg  <= srem_next;
        sroot_reg <= sroot_next;
        root_reg  <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/sw6_ctrl.sv
// Controller state machine: sequences the sum updates, the per-channel roots and the output.
module sw6_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sw6_pkg::dp_cmd_t     cmd,
    input  sw6_pkg::dp_status_t  status
);
    import sw6_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [WIN_W-1:0]   fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;

    logic               full;
    logic               last_ch;
    logic               out_free;

    assign full     = fill_reg == WIN_W'(WINDOW);
    assign last_ch  = ch_reg == CH_W'(LAST_CH);
    assign out_free = !out_valid_reg || !result_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM:  state_next = last_ch ? ST_NEXT : ST_READ;
            ST_NEXT:
            begin
                if (full || fill_reg == WIN_W'(WINDOW - 1))
                begin
                    state_next = ST_PREP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (status.root_done)
                begin
                    state_next = last_ch ? ST_OUTPUT : ST_PREP;
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Counters and the output valid flag.
    always_comb
    begin
        ch_next        = ch_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                ch_next = '0;
            end
            ST_ACCUM:
            begin
                ch_next = last_ch ? '0 : ch_reg + 1'b1;
            end
            ST_NEXT:
            begin
                if (base_reg == ADDR_W'(RING_DEPTH - CHANNELS))
                begin
                    base_next = '0;
                end
                else
                begin
                    base_next = base_reg + ADDR_W'(CHANNELS);
                end
                if (!full)
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (status.root_done)
                begin
                    ch_next = last_ch ? '0 : ch_reg + 1'b1;
                end
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                ch_next = ch_reg;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd            = '0;
        cmd.ring_addr  = base_reg + ADDR_W'(ch_reg);
        cmd.ch         = ch_reg;
        cmd.full       = full;
        sample_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.capture  = sample_valid;
            end
            ST_READ:   cmd.ring_rd = 1'b1;
            ST_SQUARE:
            begin
                cmd.square  = 1'b1;
                cmd.ring_wr = 1'b1;
            end
            ST_ACCUM:  cmd.accum = 1'b1;
            ST_PREP:   cmd.prep = 1'b1;
            ST_DIFF:   cmd.root_start = 1'b1;
            ST_WAIT:   cmd.store_root = status.root_done;
            ST_OUTPUT: cmd.load_out = out_free;
            default:   cmd.capture = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            base_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            base_reg      <= base_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

>>> rtl/sw6_dp.sv
// Datapath: sample ring, running sums, variance numerator and the result register.
module sw6_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sw6_pkg::sample_t     sample,
    input  sw6_pkg::dp_cmd_t     cmd,
    output sw6_pkg::dp_status_t  status,
    output sw6_pkg::result_t     result
);
    import sw6_pkg::*;

    logic signed [SMP_W-1:0] smp_reg [CHANNELS];
    logic signed [SMP_W-1:0] old_reg, old_next;
    logic signed [SMP_W-1:0] new_reg, new_next;
    logic [SQR_W-1:0]        old_sq_reg, old_sq_next;
    logic [SQR_W-1:0]        new_sq_reg, new_sq_next;
    logic signed [SUM_W-1:0] sum_reg [CHANNELS];
    logic signed [SUM_W-1:0] sum_next;
    logic [SQS_W-1:0]        sqs_reg [CHANNELS];
    logic [SQS_W-1:0]        sqs_next;
    logic [NUM_W-1:0]        a_reg, a_next;
    logic [NUM_W-1:0]        b_reg, b_next;
    logic [ROOT_W-1:0]       res_reg [CHANNELS];
    result_t                 result_reg, result_next;

    logic [SMP_W-1:0]        ring_rdata;
    logic signed [2*SMP_W-1:0] old_prod;
    logic signed [2*SMP_W-1:0] new_prod;
    logic signed [SUM_W-1:0] sum_sel;
    logic signed [SUM_W-1:0] sum_abs;
    logic [MAG_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    logic                    root_done;
    logic [ROOT_W-1:0]       root;

    sw6_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.ring_wr),
        .wr_addr (cmd.ring_addr),
        .wr_data (new_next),
        .rd_en   (cmd.ring_rd),
        .rd_addr (cmd.ring_addr),
        .rd_data (ring_rdata)
    );

    sw6_divsqrt u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .num   (num),
        .done  (root_done),
        .root  (root)
    );

    always_comb
    begin
        // While the window fills, no sample leaves the sums.
        old_next    = cmd.full ? $signed(ring_rdata) : '0;
        new_next    = smp_reg[cmd.ch];
        old_prod    = old_next * old_next;
        new_prod    = new_next * new_next;
        old_sq_next = old_prod[SQR_W-1:0];
        new_sq_next = new_prod[SQR_W-1:0];

        sum_next = sum_reg[cmd.ch] + SUM_W'(new_reg) - SUM_W'(old_reg);
        sqs_next = sqs_reg[cmd.ch] + SQS_W'(new_sq_reg) - SQS_W'(old_sq_reg);

        sum_sel = sum_reg[cmd.ch];
        sum_abs = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
        mag     = sum_abs[MAG_W-1:0];
        b_next  = NUM_W'(mag) * NUM_W'(mag);
        a_next  = NUM_W'(sqs_reg[cmd.ch]) * NUM_W'(WINDOW);
        num     = (a_reg >= b_reg) ? a_reg - b_reg : '0;

        result_next.sd_accel_x = res_reg[0];
        result_next.sd_accel_y = res_reg[1];
        result_next.sd_accel_z = res_reg[2];
        result_next.sd_gyro_x  = res_reg[3];
        result_next.sd_gyro_y  = res_reg[4];
        result_next.sd_gyro_z  = res_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                sqs_reg[i] <= '0;
            end
        end
        else if (cmd.accum)
        begin
            sum_reg[cmd.ch] <= sum_next;
            sqs_reg[cmd.ch] <= sqs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg[0] <= sample.accel_x;
            smp_reg[1] <= sample.accel_y;
            smp_reg[2] <= sample.accel_z;
            smp_reg[3] <= sample.gyro_x;
            smp_reg[4] <= sample.gyro_y;
            smp_reg[5] <= sample.gyro_z;
        end
        if (cmd.square)
        begin
            old_reg    <= old_next;
            new_reg    <= new_next;
            old_sq_reg <= old_sq_next;
            new_sq_reg <= new_sq_next;
        end
        if (cmd.prep)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (cmd.store_root)
        begin
            res_reg[cmd.ch] <= root;
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign status.root_done = root_done;
    assign result           = result_reg;

endmodule

>>> rtl/sliding_window_stddev_six_channel.sv
// Six-channel sliding-window standard deviation, top level.
// While the window fills, a transaction only updates the sums; from the sample that fills it on,
// the shared root unit (23 steps plus one scaling) then takes the root of each channel in turn.
// The next sample is taken while a finished result waits in the output register.
// rst_n (asynchronous, active low) empties the window and clears the sums and controls;
// the sample ring keeps its contents, which are used only after being rewritten.
`include "sliding_window_stddev_six_channel_assert.svh"

module sliding_window_stddev_six_channel (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sw6_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_stall,
    output sw6_pkg::result_t result
);
    import sw6_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_accept;

    assign in_accept = sample_valid && !sample_stall;

    sw6_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    sw6_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    `SW6_ASSERT_NXT(a_busy_after_accept, in_accept, sample_stall, "block not busy after accept")
    `SW6_ASSERT_NXT(a_load_shows_valid, cmd.load_out, result_valid, "result load not visible")
    `SW6_ASSERT_NXT(a_read_then_write, cmd.ring_rd, cmd.ring_wr, "ring read not followed by write")
    `SW6_ASSERT_IMP(a_root_while_busy, status.root_done, sample_stall, "root finished while idle")

endmodule

>>> tb/sv/sliding_window_stddev_six_channel_tb.sv
// Self-checking testbench for the six-channel sliding-window standard deviation block.
module sliding_window_stddev_six_channel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sw6_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 240;
    localparam int PAUSE_AT     = 120;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 4000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        sample_t smp;
        int      reps;
        bit      typed;
        result_t sd;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Predictor state: the sample window and the running sums per channel.
    int      win_ring [WINDOW][CHANNELS];
    int      ring_slot;
    int      ring_fill;
    longint  run_sum [CHANNELS];
    longint  run_sqsum [CHANNELS];
    int      drift_bias [CHANNELS];

    result_t     sd_expected [$];
    stim_row_t   directed_rows [$];
    int          mismatches;
    int          results_checked;
    int          burst_left;
    int unsigned cycle_count = 0;
    string       sd_names [CHANNELS] = '{"sd_accel_x", "sd_accel_y", "sd_accel_z",
                                        "sd_gyro_x", "sd_gyro_y", "sd_gyro_z"};

    sliding_window_stddev_six_channel i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sliding_window_stddev_six_channel] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int floor_root(input longint q);
        longint root;
        longint trial;
        root = 0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= q)
                root = trial;
        end
        return int'(root);
    endfunction

    function automatic void update_window_stddev(input sample_t s, output bit produced,
                                                 output result_t sd);
        logic [CHANNELS*SMP_W-1:0]  s_bits;
        logic [CHANNELS*ROOT_W-1:0] sd_bits;
        bit     full;
        int     x;
        int     old;
        int     root;
        longint num;
        s_bits = s;
        full = (ring_fill >= WINDOW);
        for (int c = 0; c < CHANNELS; c++)
        begin
            x = int'($signed(s_bits[(LAST_CH-c)*SMP_W +: SMP_W]));
            // The oldest sample leaves the sums before the new one enters.
            if (full)
            begin
                old = win_ring[ring_slot][c];
                run_sum[c] -= old;
                run_sqsum[c] -= longint'(old) * old;
            end
            run_sum[c] += x;
            run_sqsum[c] += longint'(x) * x;
            win_ring[ring_slot][c] = x;
        end
        ring_slot = (ring_slot + 1) % WINDOW;
        if (!full)
            ring_fill++;
        produced = (ring_fill >= WINDOW);
        sd_bits = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            num = longint'(WINDOW) * run_sqsum[c] - run_sum[c] * run_sum[c];
            if (num < 0)
                num = 0;
            root = floor_root(num / (longint'(WINDOW) * WINDOW));
            sd_bits[(LAST_CH-c)*ROOT_W +: ROOT_W] = root[ROOT_W-1:0];
        end
        sd = sd_bits;
    endfunction

    function automatic void add_row(input int ax, input int ay, input int az, input int gx,
                                    input int gy, input int gz, input int reps,
                                    input bit typed, input int sd_all);
        stim_row_t row;
        row.smp.accel_x = ax[SMP_W-1:0];
        row.smp.accel_y = ay[SMP_W-1:0];
        row.smp.accel_z = az[SMP_W-1:0];
        row.smp.gyro_x  = gx[SMP_W-1:0];
        row.smp.gyro_y  = gy[SMP_W-1:0];
        row.smp.gyro_z  = gz[SMP_W-1:0];
        row.reps  = reps;
        row.typed = typed;
        row.sd.sd_accel_x = sd_all[ROOT_W-1:0];
        row.sd.sd_accel_y = sd_all[ROOT_W-1:0];
        row.sd.sd_accel_z = sd_all[ROOT_W-1:0];
        row.sd.sd_gyro_x  = sd_all[ROOT_W-1:0];
        row.sd.sd_gyro_y  = sd_all[ROOT_W-1:0];
        row.sd.sd_gyro_z  = sd_all[ROOT_W-1:0];
        directed_rows.push_back(row);
    endfunction

    // Half full-range noise; the rest drifting sensor-like data, extremes or one value on all channels.
    function automatic sample_t random_sample();
        logic [CHANNELS*SMP_W-1:0] bits;
        int mode;
        int v;
        int common;
        mode = $urandom_range(0, 9);
        common = $urandom;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (mode <= 4)
                v = $urandom;
            else if (mode <= 7)
            begin
                if ($urandom_range(0, 15) == 0)
                    drift_bias[c] = int'($urandom_range(0, 60000)) - 30000;
                v = drift_bias[c] + int'($urandom_range(0, 127)) - 64;
            end
            else if (mode == 8)
            begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            else
                v = common;
            bits[(LAST_CH-c)*SMP_W +: SMP_W] = v[SMP_W-1:0];
        end
        return bits;
    endfunction

    // Offers one sample, in bursts with random gaps, and records what it should produce.
    task automatic send_sample(input sample_t s, input bit use_typed, input result_t typed_sd);
        bit      produced;
        result_t sd_pred;
        int      gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 450) : $urandom_range(0, 3);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        update_window_stddev(s, produced, sd_pred);
        if (produced)
            sd_expected.push_back(use_typed ? typed_sd : sd_pred);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t                    want;
        logic [CHANNELS*ROOT_W-1:0] got_bits;
        logic [CHANNELS*ROOT_W-1:0] want_bits;
        int                         got_f;
        int                         want_f;
        if (rst_n && result_valid && !result_stall)
        begin
            if (sd_expected.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_checked));
            else
            begin
                want = sd_expected.pop_front();
                got_bits = result;
                want_bits = want;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    got_f  = int'(got_bits[(LAST_CH-c)*ROOT_W +: ROOT_W]);
                    want_f = int'(want_bits[(LAST_CH-c)*ROOT_W +: ROOT_W]);
                    if (got_f != want_f)
                        report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                                  results_checked, sd_names[c], got_f, want_f));
                end
            end
            results_checked++;
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off so the block backs up.
    initial
    begin
        int hold_left;
        int mode;
        int phase;
        bit held;
        result_stall = 1'b0;
        hold_left = 0;
        mode = 0;
        phase = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (phase == 0)
            begin
                mode = $urandom_range(0, 3);
                phase = $urandom_range(20, 200);
            end
            phase--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= 1'($urandom_range(0, 1));
                    2: result_stall <= ($urandom_range(0, 7) == 0);
                    default: result_stall <= (phase % 4 != 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        mismatches = 0;
        results_checked = 0;
        burst_left = 0;
        ring_slot = 0;
        ring_fill = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            run_sum[c] = 0;
            run_sqsum[c] = 0;
            drift_bias[c] = 0;
        end

        // Half the window at the top of the range and half at the bottom: sd is 32767.
        add_row( 32767,  32767,  32767, -32768, -32768, -32768, 50, 1'b0, 0);
        add_row(-32768, -32768, -32768,  32767,  32767,  32767, 49, 1'b0, 0);
        add_row(-32768, -32768, -32768,  32767,  32767,  32767,  1, 1'b1, 32767);
        add_row(     0,      0,      0,      0,      0,      0,  1, 1'b0, 0);
        add_row(    -1,     -1,     -1,     -1,     -1,     -1,  1, 1'b0, 0);
        add_row(     1,      1,      1,      1,      1,      1,  1, 1'b0, 0);
        add_row( 21845, -21846,  21845, -21846,  21845, -21846,  1, 1'b0, 0);
        add_row(-32768,  32767,      0,     -1,      1,  21845,  1, 1'b0, 0);
        add_row( 32767, -32768,     -1,      0, -21846,      1,  1, 1'b0, 0);
        add_row(   256,   -256,   4096,  -4096,    127,   -128,  1, 1'b0, 0);
        // A full window of one constant sample has no spread at all.
        add_row(-32768,  32767,      0,     -1,      1,  23130, 100, 1'b1, 0);
        add_row( 12345, -12345,  30000, -30000,      7,     -7,  1, 1'b0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
            for (int k = 0; k < directed_rows[r].reps; k++)
                send_sample(directed_rows[r].smp,
                            directed_rows[r].typed && (k == directed_rows[r].reps - 1),
                            directed_rows[r].sd);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == PAUSE_AT)
            begin
                @(negedge clk);
                sample_valid <= 1'b0;
                while (sd_expected.size() != 0)
                    @(negedge clk);
                burst_left = 0;
            end
            send_sample(random_sample(), 1'b0, '0);
        end
        @(negedge clk);
        sample_valid <= 1'b0;

        while (sd_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[sliding_window_stddev_six_channel] OK");
        else
            $display("[sliding_window_stddev_six_channel] ERROR");
        $finish;
    end

endmodule
